/* sv/eic_pkg.sv */
// ----------------------------------------------------------------------------
// eic_pkg: shared types and constants for the expiring ID cache
// Command codes, controller states and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package eic_pkg;

    localparam int EIC_ENTRIES    = 8;
    localparam int EIC_CMD_W      = 3;
    localparam int EIC_UID_W      = 32;
    localparam int EIC_TIMER_W    = 16;
    localparam int EIC_S_DATA_W   = 32;
    localparam int EIC_M_DATA_W   = 8;
    localparam logic [EIC_TIMER_W-1:0] EIC_HOLD_RESET = 16'd60;

    typedef enum logic [EIC_CMD_W-1:0] {
        CMD_LOOKUP = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_CLEAR  = 3'd4
    } eic_op_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MATCH = 2'd1,
        ST_APPLY = 2'd2
    } eic_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the input transfer
        logic match;  // register match/free vectors
        logic apply;  // update table, write result register
    } eic_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;  // result register full and not draining this cycle
    } eic_sts_t;

endpackage

/* sv/eic_ctrl.sv */
// ----------------------------------------------------------------------------
// eic_ctrl: command sequencer
// Steps each accepted command through match and apply; holds in apply
// until the result register can take the new result.
// ----------------------------------------------------------------------------
module eic_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output eic_pkg::eic_ctl_t ctl,
    input  eic_pkg::eic_sts_t sts
);
    import eic_pkg::*;

    eic_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_MATCH;
            end
            ST_MATCH: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        ctl.load  = 1'b0;
        ctl.match = 1'b0;
        ctl.apply = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ctl.load = s_tvalid;
            end
            ST_MATCH: begin
                ctl.match = 1'b1;
            end
            ST_APPLY: begin
                ctl.apply = !sts.out_busy;
            end
            default: ;
        endcase
    end

    a_apply_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.apply |-> !sts.out_busy)
        else $error("apply while result register busy");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.load, ctl.match, ctl.apply}))
        else $error("more than one datapath command");

    a_match_follows_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |=> ctl.match)
        else $error("match did not follow load");

endmodule

/* sv/eic_datapath.sv */
// ----------------------------------------------------------------------------
// eic_datapath: entry table, compare vectors and result register
// Compares all entries against the key in parallel, picks the lowest
// candidate with a find-first-set and applies the command.
// ----------------------------------------------------------------------------
module eic_datapath #(
    parameter int ENTRIES = eic_pkg::EIC_ENTRIES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [eic_pkg::EIC_S_DATA_W-1:0]   s_tdata,
    input  logic [eic_pkg::EIC_CMD_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [eic_pkg::EIC_M_DATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [eic_pkg::EIC_TIMER_W-1:0]    cfg_wdata,
    input  eic_pkg::eic_ctl_t                  ctl,
    output eic_pkg::eic_sts_t                  sts
);
    import eic_pkg::*;

    logic [EIC_UID_W-1:0]   id_reg    [ENTRIES];
    logic [EIC_UID_W-1:0]   id_next   [ENTRIES];
    logic [EIC_TIMER_W-1:0] timer_reg [ENTRIES];
    logic [EIC_TIMER_W-1:0] timer_next[ENTRIES];
    logic [EIC_TIMER_W-1:0] hold_reg;

    eic_op_t                op_reg;
    logic [EIC_UID_W-1:0]   key_reg;
    logic [ENTRIES-1:0]     match_reg;
    logic [ENTRIES-1:0]     free_reg;

    logic [ENTRIES-1:0]     cand;
    logic [ENTRIES-1:0]     pick;
    logic                   hit_next, placed_next;

    logic                   valid_reg;
    logic                   hit_reg, placed_reg;
    logic                   table_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= EIC_HOLD_RESET;
        end else if (cfg_we) begin
            hold_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            op_reg  <= eic_op_t'(s_tuser);
            key_reg <= s_tdata[EIC_UID_W-1:0];
        end
        if (ctl.match) begin
            for (int i = 0; i < ENTRIES; i++) begin
                match_reg[i] <= (id_reg[i] == key_reg);
                free_reg[i]  <= (timer_reg[i] == '0);
            end
        end
    end

    // lowest set bit of the candidate vector
    always_comb begin
        cand = (op_reg == CMD_INSERT) ? free_reg : match_reg;
        pick = cand & (~cand + {{(ENTRIES-1){1'b0}}, 1'b1});
    end

    always_comb begin
        hit_next    = 1'b0;
        placed_next = 1'b0;
        case (op_reg)
            CMD_LOOKUP, CMD_REMOVE: hit_next    = |match_reg;
            CMD_INSERT:             placed_next = |free_reg;
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            id_next[i]    = id_reg[i];
            timer_next[i] = timer_reg[i];
            if (ctl.apply) begin
                case (op_reg)
                    CMD_INSERT: begin
                        if (pick[i]) begin
                            id_next[i]    = key_reg;
                            timer_next[i] = hold_reg;
                        end
                    end
                    CMD_REMOVE: begin
                        if (pick[i]) begin
                            id_next[i]    = '0;
                            timer_next[i] = '0;
                        end
                    end
                    CMD_TICK: begin
                        // expired entries lose their ID, live ones count down
                        if (timer_reg[i] != '0) begin
                            timer_next[i] = timer_reg[i] - 1'b1;
                        end else begin
                            id_next[i] = '0;
                        end
                    end
                    CMD_CLEAR: begin
                        id_next[i]    = '0;
                        timer_next[i] = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (!aresetn) begin
                id_reg[i]    <= '0;
                timer_reg[i] <= '0;
            end else begin
                id_reg[i]    <= id_next[i];
                timer_reg[i] <= timer_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.apply) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.apply) begin
            hit_reg    <= hit_next;
            placed_reg <= placed_next;
        end
    end

    assign sts.out_busy = valid_reg && !m_tready;
    assign m_tvalid     = valid_reg;
    assign m_tdata      = {{(EIC_M_DATA_W-2){1'b0}}, placed_reg, hit_reg};

    always_comb begin
        table_empty = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (id_reg[i] != '0 || timer_reg[i] != '0) table_empty = 1'b0;
        end
    end

    a_pick_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.apply |-> $onehot0(pick))
        else $error("more than one entry picked");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.apply && op_reg == CMD_CLEAR) |=> table_empty)
        else $error("table not empty after clear");

    a_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !(hit_reg && placed_reg))
        else $error("hit and placed both set");

    a_valid_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid_reg) |-> $past(ctl.apply))
        else $error("result appeared without apply");

endmodule

/* sv/expiring_id_cache.sv */
// ----------------------------------------------------------------------------
// expiring_id_cache: ID table with per-entry countdown timers
// Lookup, insert, remove, tick and clear on a small table of card IDs.
// ----------------------------------------------------------------------------
// m_tvalid rises once the command has passed the compare and then the apply
// step, later only while the result register waits on m_tready.
// s_tready is high only in idle, so each command runs through the three-step
// sequencer first; the next is taken while the previous result still waits.
// Reset (aresetn low, synchronous): table empty, hold_ticks = 60.
module expiring_id_cache #(
    parameter int ENTRIES = eic_pkg::EIC_ENTRIES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [eic_pkg::EIC_S_DATA_W-1:0]  s_tdata,   // [31:0] key_uid
    input  logic [eic_pkg::EIC_CMD_W-1:0]     s_tuser,   // [2:0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [eic_pkg::EIC_M_DATA_W-1:0]  m_tdata,   // [0] hit, [1] placed
    input  logic                              cfg_we,
    input  logic [eic_pkg::EIC_TIMER_W-1:0]   cfg_wdata  // hold_ticks
);
    import eic_pkg::*;

    eic_ctl_t ctl;
    eic_sts_t sts;

    eic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    eic_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

/* tb/sv/eic_result_checker.sv */
// ----------------------------------------------------------------------------
// eic_result_checker: result checker for the expiring ID cache
// Keeps its own copy of the ID table, timers and hold setting, updates it on
// each accepted command and compares each result transfer against the oldest
// prediction. Reports mismatch and outstanding counts back to the top level.
// ----------------------------------------------------------------------------
module eic_result_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [eic_pkg::EIC_S_DATA_W-1:0]    s_tdata,   // [31:0] key_uid
    input  logic [eic_pkg::EIC_CMD_W-1:0]       s_tuser,   // [2:0] command
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [eic_pkg::EIC_M_DATA_W-1:0]    m_tdata,   // [0] hit, [1] placed
    input  logic                                cfg_we,
    input  logic [eic_pkg::EIC_TIMER_W-1:0]     cfg_wdata, // hold_ticks
    output int                                  mismatches,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import eic_pkg::*;

    typedef struct packed {
        logic hit;
        logic placed;
    } cache_result_t;

    logic [EIC_UID_W-1:0]   cached_ids    [EIC_ENTRIES];
    logic [EIC_TIMER_W-1:0] cached_timers [EIC_ENTRIES];
    logic [EIC_TIMER_W-1:0] hold_setting;
    cache_result_t          expected_results[$];
    int                     error_total;

    initial begin
        error_total = 0;
    end

    // Updates the table copy for one command and returns its result.
    function automatic cache_result_t apply_cache_command(
        input logic [EIC_CMD_W-1:0] op,
        input logic [EIC_UID_W-1:0] key
    );
        cache_result_t res;
        int            slot;
        res  = '0;
        slot = -1;
        case (op)
            CMD_LOOKUP: begin
                for (int i = 0; i < EIC_ENTRIES; i++)
                    if (cached_ids[i] == key) res.hit = 1'b1;
            end
            CMD_INSERT: begin
                for (int i = 0; i < EIC_ENTRIES; i++)
                    if (slot < 0 && cached_timers[i] == '0) slot = i;
                if (slot >= 0) begin
                    cached_ids[slot]    = key;
                    cached_timers[slot] = hold_setting;
                    res.placed          = 1'b1;
                end
            end
            CMD_REMOVE: begin
                for (int i = 0; i < EIC_ENTRIES; i++)
                    if (slot < 0 && cached_ids[i] == key) slot = i;
                if (slot >= 0) begin
                    cached_ids[slot]    = '0;
                    cached_timers[slot] = '0;
                    res.hit             = 1'b1;
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < EIC_ENTRIES; i++) begin
                    if (cached_timers[i] != '0) cached_timers[i] = cached_timers[i] - 1'b1;
                    else cached_ids[i] = '0;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < EIC_ENTRIES; i++) begin
                    cached_ids[i]    = '0;
                    cached_timers[i] = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string field, input logic exp_v, input logic act_v);
        if (exp_v !== act_v) begin
            error_total++;
            if (error_total <= 10)
                $display("%0t: %s mismatch: expected %0b got %0b", $realtime, field, exp_v,
                         act_v);
        end
    endtask

    always @(posedge aclk) begin
        cache_result_t exp_res;
        if (!aresetn) begin
            for (int i = 0; i < EIC_ENTRIES; i++) begin
                cached_ids[i]    = '0;
                cached_timers[i] = '0;
            end
            hold_setting = EIC_HOLD_RESET;
            expected_results.delete();
        end else begin
            if (cfg_we) hold_setting = cfg_wdata;
            // drain first: a result never belongs to a command taken at the same edge
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    error_total++;
                    if (error_total <= 10)
                        $display("%0t: result transfer with nothing pending: m_tdata=%h",
                                 $realtime, m_tdata);
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("hit", exp_res.hit, m_tdata[0]);
                    check_field("placed", exp_res.placed, m_tdata[1]);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_cache_command(s_tuser, s_tdata));
        end
        outstanding <= expected_results.size();
        mismatches  <= error_total;
    end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the expiring ID cache
// Directed commands for the corner cases, then random command streams under
// several hold settings with random stalls on both channels and one long
// output stall. Checking is done by eic_result_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import eic_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int PHASE_ITEMS     = 130;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic [EIC_CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [EIC_CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [EIC_S_DATA_W-1:0]   s_tdata;   // [31:0] key_uid
    logic [EIC_CMD_W-1:0]      s_tuser;   // [2:0] command
    logic                      m_tvalid;
    logic                      m_tready;
    logic [EIC_M_DATA_W-1:0]   m_tdata;   // [0] hit, [1] placed
    logic                      cfg_we;
    logic [EIC_TIMER_W-1:0]    cfg_wdata; // hold_ticks

    int   mismatches;
    int   outstanding;
    int   idle_cycles;
    logic quiet;
    logic long_hold_req;
    logic [EIC_UID_W-1:0] key_pool [8];

    always #4 aclk = ~aclk;

    expiring_id_cache DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    eic_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_command(input logic [EIC_CMD_W-1:0] op, input logic [EIC_UID_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Table must be quiet before the hold setting changes.
    task automatic set_hold_ticks(input logic [EIC_TIMER_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [EIC_CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return CMD_LOOKUP;
        if (r < 55) return CMD_INSERT;
        if (r < 72) return CMD_REMOVE;
        if (r < 92) return CMD_TICK;
        if (r < 95) return CMD_CLEAR;
        return EIC_CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    endfunction

    // Mostly keys from a small pool so lookups and removes hit.
    function automatic logic [EIC_UID_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return key_pool[$urandom_range(0, 7)];
        if (r < 85) return '0;
        return $urandom;
    endfunction

    // Output side: random stall bursts, one long hold on request, none at the end.
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [EIC_TIMER_W-1:0] hold_plan [6];
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_LOOKUP;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        idle_cycles   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset hold setting
        send_command(CMD_LOOKUP, 32'h0000_0000);  // empty entry matches zero
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'h8000_0001);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF);
        send_command(CMD_REMOVE, 32'h0000_0000);  // clears first empty entry, hits
        for (int k = CMD_UNUSED_FIRST; k <= CMD_UNUSED_LAST; k++)
            send_command(EIC_CMD_W'(k), 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'h1234_5678);
        send_command(CMD_INSERT, 32'h1234_5678);  // duplicate
        send_command(CMD_REMOVE, 32'h1234_5678);
        send_command(CMD_LOOKUP, 32'h1234_5678);  // second copy still there
        for (int k = 0; k < 6; k++)
            send_command(CMD_INSERT, $urandom);   // last one finds the table full
        send_command(CMD_TICK, 32'h0000_0000);
        send_command(CMD_CLEAR, 32'h0000_0000);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF);

        hold_plan[0] = 16'd0;
        hold_plan[1] = 16'd1;
        hold_plan[2] = 16'hFFFF;
        hold_plan[3] = 16'd3;
        hold_plan[4] = EIC_TIMER_W'($urandom_range(2, 12));
        hold_plan[5] = EIC_TIMER_W'($urandom);

        for (int phase = 0; phase < 6; phase++) begin
            set_hold_ticks(hold_plan[phase]);
            for (int k = 0; k < 8; k++) key_pool[k] = $urandom;
            if (phase == 5) quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // fill the block up behind a stalled output
                if (phase == 2 && n == 20) long_hold_req = 1'b1;
                send_command(pick_command(), pick_key());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
